FILE: sv/qeg_pkg.sv
// ============================================================================
// qeg_pkg: shared types and constants of the quadrature encoder gesture unit
// Holds the configuration, item and result structs, the register indexes,
// the reset values of the registers and the transition decode table.
// ============================================================================
package qeg_pkg;

   // Default width of the saturating step counter.
   localparam int COUNT_WIDTH_DEF = 16;

   // Width of the step count carried in a result item.
   localparam int STEP_COUNT_W = 16;

   // Configuration register indexes.
   localparam int CSR_INDEX_W = 2;
   localparam logic [CSR_INDEX_W-1:0] CSR_STEP_THRESHOLD   = 2'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_SETTLE_TICKS     = 2'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_INVERT_DIRECTION = 2'd2;

   // Configuration data width and reset values.
   localparam int CSR_DATA_W = 8;
   localparam logic [7:0] STEP_THRESHOLD_RST = 8'd4;
   localparam logic [7:0] SETTLE_TICKS_RST   = 8'd10;

   // Item kinds.
   localparam logic KIND_PIN  = 1'b0;
   localparam logic KIND_TICK = 1'b1;

   // Decoded step direction codes.
   localparam logic [1:0] STEP_NONE = 2'd0;
   localparam logic [1:0] STEP_UP   = 2'd1;
   localparam logic [1:0] STEP_DOWN = 2'd2;

   // Configuration as seen by the core.
   typedef struct packed {
      logic [7:0] step_threshold;
      logic [7:0] settle_ticks;
      logic       invert_direction;
   } cfg_type;

   // One input item.
   typedef struct packed {
      logic req_type;
      logic pin_a;
      logic pin_b;
      logic pin_push;
   } item_type;

   // One result item.
   typedef struct packed {
      logic                    turned_right;
      logic                    turned_left;
      logic                    pressed;
      logic [STEP_COUNT_W-1:0] step_count;
   } result_type;

   // Direction of the transition {old A, old B, new A, new B}.
   function automatic logic [1:0] decode_step(input logic [3:0] code);
      logic [1:0] dir;
      case (code)
         4'b1101, 4'b0100, 4'b0010, 4'b1011: dir = STEP_UP;
         4'b1110, 4'b0111, 4'b0001, 4'b1000: dir = STEP_DOWN;
         default:                            dir = STEP_NONE;
      endcase
      return dir;
   endfunction

endpackage

FILE: sv/qeg_csr.sv
// ============================================================================
// qeg_csr: configuration registers
// Holds step threshold, settle time and direction inversion; writes to an
// unused index are dropped.
// ============================================================================
module qeg_csr (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           csr_valid,
   output logic                           csr_ready,
   input  logic [qeg_pkg::CSR_INDEX_W-1:0] csr_index,
   input  logic [qeg_pkg::CSR_DATA_W-1:0]  csr_data,
   output qeg_pkg::cfg_type               cfg
);
   import qeg_pkg::*;

   cfg_type cfg_ff;
   cfg_type cfg_in;

   // Writes are always taken.
   assign csr_ready = 1'b1;

   // Register update on a completed write.
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid) begin
         case (csr_index)
            CSR_STEP_THRESHOLD:   cfg_in.step_threshold   = csr_data;
            CSR_SETTLE_TICKS:     cfg_in.settle_ticks     = csr_data;
            CSR_INVERT_DIRECTION: cfg_in.invert_direction = csr_data[0];
            default:              cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.step_threshold   <= STEP_THRESHOLD_RST;
         cfg_ff.settle_ticks     <= SETTLE_TICKS_RST;
         cfg_ff.invert_direction <= 1'b0;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

FILE: sv/qeg_core.sv
// ============================================================================
// qeg_core: step counter, push latch and gesture state machine
// Updates the encoder state for one item per cycle while fire is set and forms its result.
// ============================================================================
module qeg_core #(
   parameter int COUNT_WIDTH = qeg_pkg::COUNT_WIDTH_DEF
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 fire,
   input  qeg_pkg::item_type    item,
   input  qeg_pkg::cfg_type     cfg,
   output qeg_pkg::result_type  result
);
   import qeg_pkg::*;

   // Width for threshold compares: holds the count and a negated 8-bit value.
   localparam int CMP_W = ((COUNT_WIDTH > 9) ? COUNT_WIDTH : 9) + 1;

   localparam logic signed [COUNT_WIDTH-1:0] COUNT_MAX = {1'b0, {(COUNT_WIDTH-1){1'b1}}};
   localparam logic signed [COUNT_WIDTH-1:0] COUNT_MIN = {1'b1, {(COUNT_WIDTH-1){1'b0}}};

   // Phase codes.
   localparam logic [1:0] PH_IDLE  = 2'd0;
   localparam logic [1:0] PH_WAIT  = 2'd1;
   localparam logic [1:0] PH_CHECK = 2'd2;

   logic                          primed_ff, primed_in;
   logic [2:0]                    history_ff, history_in;
   logic [1:0]                    last_ab_ff, last_ab_in;
   logic signed [COUNT_WIDTH-1:0] total_ff, total_in;
   logic signed [COUNT_WIDTH-1:0] saved_ff, saved_in;
   logic                          push_ff, push_in;
   logic [1:0]                    phase_ff, phase_in;
   logic [7:0]                    wait_ff, wait_in;

   logic [2:0]              now_pins;
   logic [2:0]              changed;
   logic [1:0]              dir;
   logic [1:0]              dir_eff;
   logic signed [CMP_W-1:0] total_wide;
   logic signed [CMP_W-1:0] thr_wide;
   logic                    over_thr;
   logic                    rep_right, rep_left, rep_press;

   // Pin sample decode.
   assign now_pins = {item.pin_push, item.pin_b, item.pin_a};
   assign changed  = now_pins ^ history_ff;
   assign dir      = decode_step({last_ab_ff, item.pin_a, item.pin_b});
   always_comb begin
      dir_eff = dir;
      if (cfg.invert_direction) begin
         case (dir)
            STEP_UP:   dir_eff = STEP_DOWN;
            STEP_DOWN: dir_eff = STEP_UP;
            default:   dir_eff = STEP_NONE;
         endcase
      end
   end

   // Threshold compare in a width that holds both operands.
   assign total_wide = CMP_W'(total_ff);
   assign thr_wide   = CMP_W'(signed'({1'b0, cfg.step_threshold}));
   assign over_thr   = (total_wide > thr_wide) || (total_wide < -thr_wide);

   // Next state and report pulses.
   always_comb begin
      primed_in  = primed_ff;
      history_in = history_ff;
      last_ab_in = last_ab_ff;
      total_in   = total_ff;
      saved_in   = saved_ff;
      push_in    = push_ff;
      phase_in   = phase_ff;
      wait_in    = wait_ff;
      rep_right  = 1'b0;
      rep_left   = 1'b0;
      rep_press  = 1'b0;
      if (item.req_type == KIND_PIN) begin
         history_in = now_pins;
         if (!primed_ff) begin
            last_ab_in = {item.pin_a, item.pin_b};
            primed_in  = 1'b1;
         end else begin
            if (changed[1:0] != 2'b00) begin
               if (dir_eff == STEP_UP && total_ff != COUNT_MAX) begin
                  total_in = total_ff + COUNT_WIDTH'(1);
               end else if (dir_eff == STEP_DOWN && total_ff != COUNT_MIN) begin
                  total_in = total_ff - COUNT_WIDTH'(1);
               end
               last_ab_in = {item.pin_a, item.pin_b};
            end
            if (changed[2] && !item.pin_push) begin
               push_in = 1'b1;
            end
         end
      end else begin
         case (phase_ff)
            PH_WAIT: begin
               if (wait_ff == cfg.settle_ticks) begin
                  phase_in = PH_CHECK;
                  wait_in  = 8'd0;
               end else begin
                  wait_in = wait_ff + 8'd1;
               end
            end
            PH_CHECK: begin
               if (saved_ff == total_ff) begin
                  rep_right = (total_ff > 0);
                  rep_left  = (total_ff < 0);
               end
               if (push_ff) begin
                  rep_press = 1'b1;
                  push_in   = 1'b0;
               end
               total_in = '0;
               phase_in = PH_IDLE;
            end
            default: begin
               // Idle, and the unused code behaves the same.
               if (over_thr || push_ff) begin
                  saved_in = total_ff;
                  phase_in = PH_WAIT;
               end
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         primed_ff  <= 1'b0;
         history_ff <= 3'd0;
         last_ab_ff <= 2'd0;
         total_ff   <= '0;
         saved_ff   <= '0;
         push_ff    <= 1'b0;
         phase_ff   <= PH_IDLE;
         wait_ff    <= 8'd0;
      end else if (fire) begin
         primed_ff  <= primed_in;
         history_ff <= history_in;
         last_ab_ff <= last_ab_in;
         total_ff   <= total_in;
         saved_ff   <= saved_in;
         push_ff    <= push_in;
         phase_ff   <= phase_in;
         wait_ff    <= wait_in;
      end
   end

   // Result of the item in process.
   assign result.turned_right = rep_right;
   assign result.turned_left  = rep_left;
   assign result.pressed      = rep_press;
   assign result.step_count   = STEP_COUNT_W'(total_in);

endmodule

FILE: sv/quadrature_encoder_gesture_unit.sv
// ============================================================================
// quadrature_encoder_gesture_unit: encoder decoder with settled gestures
// Counts quadrature steps and push presses from pin samples and reports
// settled right and left turns and presses on millisecond ticks.
// ============================================================================
//
// Channel  Direction  Ports                          Content
// req      in         req_tvalid/tready/tdata/tuser  pin sample or tick
// rsp      out        rsp_tvalid/tready/tdata        pulses and step count
// csr      in         csr_valid/ready/index/data     register writes
//
// Every item produces one result item: it is held in the input register, then
// passes through the state update into the output register. One item is
// accepted per cycle while the output is taken.
// A stalled output holds its item; the input register takes one more item.
// Synchronous reset clears the valid flags and all core state and loads register reset values.
//
module quadrature_encoder_gesture_unit #(
   parameter int COUNT_WIDTH = qeg_pkg::COUNT_WIDTH_DEF
) (
   input  logic                            clock,
   input  logic                            reset,
   // Input items.
   input  logic                            req_tvalid,
   output logic                            req_tready,
   input  logic [7:0]                      req_tdata,  // pin_a, pin_b, pin_push, zero fill
   input  logic [0:0]                      req_tuser,  // req_type
   // Result items.
   output logic                            rsp_tvalid,
   input  logic                            rsp_tready,
   output logic [23:0]                     rsp_tdata,  // turned_right, turned_left, pressed,
                                                       // step_count[15:0], zero fill
   // Configuration writes.
   input  logic                            csr_valid,
   output logic                            csr_ready,
   input  logic [qeg_pkg::CSR_INDEX_W-1:0] csr_index,
   input  logic [qeg_pkg::CSR_DATA_W-1:0]  csr_data
);
   import qeg_pkg::*;

   cfg_type    cfg;
   item_type   in_item_ff;
   logic       in_valid_ff;
   result_type result;
   result_type rsp_ff;
   logic       rsp_valid_ff;
   logic       advance;

   qeg_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_data  (csr_data),
      .cfg       (cfg)
   );

   // The held item moves on when the output register is free or being taken.
   assign advance    = in_valid_ff && (!rsp_valid_ff || rsp_tready);
   assign req_tready = !in_valid_ff || advance;

   // Input register.
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req_tready) begin
         in_valid_ff <= req_tvalid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_tvalid && req_tready) begin
         in_item_ff.req_type <= req_tuser[0];
         in_item_ff.pin_a    <= req_tdata[0];
         in_item_ff.pin_b    <= req_tdata[1];
         in_item_ff.pin_push <= req_tdata[2];
      end
   end

   qeg_core #(
      .COUNT_WIDTH (COUNT_WIDTH)
   ) u_core (
      .clock  (clock),
      .reset  (reset),
      .fire   (advance),
      .item   (in_item_ff),
      .cfg    (cfg),
      .result (result)
   );

   // Output register.
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (advance) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         rsp_ff <= result;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {5'd0, rsp_ff.step_count, rsp_ff.pressed,
                        rsp_ff.turned_left, rsp_ff.turned_right};

endmodule

FILE: sim/testbench.sv
// ============================================================================
// testbench: self-checking regression of quadrature_encoder_gesture_unit
// Drives pin samples and millisecond ticks with random gaps and output
// stalls, predicts every result item from a shadow of the counting and
// gesture logic, and compares each result field by field in order.
// ============================================================================
module testbench;
   import qeg_pkg::*;

   localparam int DRAIN_CYCLES   = 4;
   localparam int HOLD_CYCLES    = 300;
   localparam int WATCHDOG_LIMIT = 3000;
   localparam int MAX_REPORTS    = 20;

   // Index that selects no register.
   localparam logic [CSR_INDEX_W-1:0] CSR_UNUSED_INDEX = 2'd3;

   localparam logic signed [STEP_COUNT_W-1:0] COUNT_MAX = 16'sh7FFF;
   localparam logic signed [STEP_COUNT_W-1:0] COUNT_MIN = 16'sh8000;

   // AB levels ({A, B}) in the order of one forward quadrature cycle.
   localparam logic [1:0] QUAD_SEQ [4] = '{2'b00, 2'b10, 2'b11, 2'b01};

   // Gesture phase codes.
   localparam logic [1:0] PHASE_IDLE   = 2'd0;
   localparam logic [1:0] PHASE_SETTLE = 2'd1;
   localparam logic [1:0] PHASE_CHECK  = 2'd2;

   logic                   clock = 1'b0;
   logic                   reset = 1'b1;
   logic                   req_tvalid = 1'b0;
   logic                   req_tready;
   logic [7:0]             req_tdata = '0;   // pin_a, pin_b, pin_push, zero fill
   logic [0:0]             req_tuser = '0;   // req_type
   logic                   rsp_tvalid;
   logic                   rsp_tready = 1'b0;
   logic [23:0]            rsp_tdata;        // turned_right, turned_left, pressed,
                                             // step_count[15:0], zero fill
   logic                   csr_valid = 1'b0;
   logic                   csr_ready;
   logic [CSR_INDEX_W-1:0] csr_index = '0;
   logic [CSR_DATA_W-1:0]  csr_data = '0;

   quadrature_encoder_gesture_unit dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_data   (csr_data)
   );

   // Shadow of the configuration registers and the counting state.
   cfg_type                        shadow_cfg = '{STEP_THRESHOLD_RST, SETTLE_TICKS_RST, 1'b0};
   logic                           knob_primed = 1'b0;
   logic [2:0]                     pin_levels = '0;   // bit0 A, bit1 B, bit2 push
   logic [1:0]                     prev_ab = '0;      // A in bit 1, B in bit 0
   logic signed [STEP_COUNT_W-1:0] encoder_count = '0;
   logic signed [STEP_COUNT_W-1:0] snapshot_count = '0;
   logic                           press_pending = 1'b0;
   logic [1:0]                     gesture_phase = PHASE_IDLE;
   logic [7:0]                     settle_count = '0;

   result_type expected_reports [$];

   // Stimulus position and traffic shaping.
   int   quad_pos = 0;
   logic push_level = 1'b1;
   int   idle_pct = 30;
   int   stall_pct = 30;
   int   stall_left = 0;
   int   hold_left = 0;
   bit   hold_request = 1'b0;

   int errors = 0;
   int sent_items = 0;
   int right_seen = 0;
   int left_seen = 0;
   int press_seen = 0;
   int quiet_cycles = 0;

   // Clock with a period of 10.
   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // Position of an AB pair within the forward quadrature cycle.
   function automatic int quad_index(input logic [1:0] ab);
      case (ab)
         2'b00:   return 0;
         2'b10:   return 1;
         2'b11:   return 2;
         default: return 3;
      endcase
   endfunction

   // Gap length: mostly none, mostly short when there is one, now and then long.
   function automatic int pick_gap(input int pct);
      if ($urandom_range(0, 99) >= pct)
         return 0;
      if ($urandom_range(0, 9) < 8)
         return $urandom_range(1, 3);
      return $urandom_range(8, 30);
   endfunction

   // Advances the shadow state by one item and returns the result it causes.
   task automatic predict_gesture(input item_type it, output result_type rep);
      logic [2:0]                     levels;
      logic [2:0]                     changed;
      logic [1:0]                     ab;
      int                             dir;
      logic signed [STEP_COUNT_W-1:0] thr;
      rep = '0;
      thr = {8'd0, shadow_cfg.step_threshold};
      if (it.req_type == KIND_TICK) begin
         case (gesture_phase)
            PHASE_SETTLE: begin
               if (settle_count == shadow_cfg.settle_ticks) begin
                  gesture_phase = PHASE_CHECK;
                  settle_count = '0;
               end else begin
                  settle_count = settle_count + 8'd1;
               end
            end
            PHASE_CHECK: begin
               // A turn is reported only if the count held still while settling.
               if (snapshot_count == encoder_count) begin
                  if (encoder_count > 0)
                     rep.turned_right = 1'b1;
                  else if (encoder_count < 0)
                     rep.turned_left = 1'b1;
               end
               if (press_pending) begin
                  rep.pressed = 1'b1;
                  press_pending = 1'b0;
               end
               encoder_count = '0;
               gesture_phase = PHASE_IDLE;
            end
            default: begin
               if (encoder_count > thr || encoder_count < -thr || press_pending) begin
                  snapshot_count = encoder_count;
                  gesture_phase = PHASE_SETTLE;
               end
            end
         endcase
      end else begin
         levels = {it.pin_push, it.pin_b, it.pin_a};
         ab = {it.pin_a, it.pin_b};
         if (!knob_primed) begin
            // The first sample after reset only records the pins.
            pin_levels = levels;
            prev_ab = ab;
            knob_primed = 1'b1;
         end else begin
            changed = levels ^ pin_levels;
            pin_levels = levels;
            if (changed[1:0] != 2'b00) begin
               case ((quad_index(ab) - quad_index(prev_ab)) & 3)
                  1:       dir = 1;
                  3:       dir = -1;
                  default: dir = 0;
               endcase
               if (shadow_cfg.invert_direction)
                  dir = -dir;
               if (dir > 0 && encoder_count < COUNT_MAX)
                  encoder_count = encoder_count + 16'sd1;
               else if (dir < 0 && encoder_count > COUNT_MIN)
                  encoder_count = encoder_count - 16'sd1;
               prev_ab = ab;
            end
            if (changed[2] && !it.pin_push)
               press_pending = 1'b1;
         end
      end
      rep.step_count = encoder_count;
   endtask

   // Offers one item, waits until it is taken and records its expected result.
   task automatic send_item(input item_type it);
      int         gap;
      result_type rep;
      gap = pick_gap(idle_pct);
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= it.req_type;
      req_tdata  <= {5'd0, it.pin_push, it.pin_b, it.pin_a};
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      predict_gesture(it, rep);
      expected_reports.push_back(rep);
      sent_items++;
   endtask

   task automatic send_pin(input logic [1:0] ab, input logic push);
      item_type it;
      it.req_type = KIND_PIN;
      it.pin_a    = ab[1];
      it.pin_b    = ab[0];
      it.pin_push = push;
      quad_pos    = quad_index(ab);
      push_level  = push;
      send_item(it);
   endtask

   task automatic send_ticks(input int n);
      item_type it;
      it = '0;
      it.req_type = KIND_TICK;
      repeat (n) send_item(it);
   endtask

   // Turns the knob n steps forward (dir 1) or backward (dir -1).
   task automatic move_knob(input int dir, input int n);
      repeat (n) send_pin(QUAD_SEQ[2'((quad_pos + dir) & 3)], push_level);
   endtask

   task automatic set_push(input logic level);
      send_pin(QUAD_SEQ[2'(quad_pos)], level);
   endtask

   // Stops offering items and waits until every result item has come out.
   task automatic drain_pipeline();
      req_tvalid <= 1'b0;
      @(posedge clock);
      while (expected_reports.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   // Register write, issued only once the block has nothing in flight.
   task automatic write_csr(input logic [CSR_INDEX_W-1:0] idx,
                            input logic [CSR_DATA_W-1:0] value);
      drain_pipeline();
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= value;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      csr_valid <= 1'b0;
      case (idx)
         CSR_STEP_THRESHOLD:   shadow_cfg.step_threshold = value;
         CSR_SETTLE_TICKS:     shadow_cfg.settle_ticks = value;
         CSR_INVERT_DIRECTION: shadow_cfg.invert_direction = value[0];
         default: ;
      endcase
   endtask

   task automatic configure(input logic [7:0] thr, input logic [7:0] settle, input logic inv);
      write_csr(CSR_STEP_THRESHOLD, thr);
      write_csr(CSR_SETTLE_TICKS, settle);
      write_csr(CSR_INVERT_DIRECTION, {7'd0, inv});
   endtask

   // Compares one result item with the oldest expectation.
   task automatic check_report(input logic [23:0] word);
      result_type got;
      result_type want;
      got.turned_right = word[0];
      got.turned_left  = word[1];
      got.pressed      = word[2];
      got.step_count   = word[18:3];
      right_seen += got.turned_right;
      left_seen  += got.turned_left;
      press_seen += got.pressed;
      if (expected_reports.size() == 0) begin
         errors++;
         if (errors <= MAX_REPORTS)
            $display("%0t: result item %h arrived with none expected", $time, word);
      end else begin
         want = expected_reports.pop_front();
         if (got != want) begin
            errors++;
            if (errors <= MAX_REPORTS) begin
               if (got.turned_right !== want.turned_right)
                  $display("%0t: turned_right expected %0b actual %0b",
                           $time, want.turned_right, got.turned_right);
               if (got.turned_left !== want.turned_left)
                  $display("%0t: turned_left expected %0b actual %0b",
                           $time, want.turned_left, got.turned_left);
               if (got.pressed !== want.pressed)
                  $display("%0t: pressed expected %0b actual %0b",
                           $time, want.pressed, got.pressed);
               if (got.step_count !== want.step_count)
                  $display("%0t: step_count expected %0d actual %0d", $time,
                           $signed(want.step_count), $signed(got.step_count));
            end
         end
      end
   endtask

   // Result side: checks accepted items and drives random stalls and hold-offs.
   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready)
         check_report(rsp_tdata);
      if (hold_request) begin
         hold_left = HOLD_CYCLES;
         hold_request = 1'b0;
      end
      if (hold_left > 0) begin
         hold_left--;
         rsp_tready <= 1'b0;
      end else if (stall_left > 0) begin
         stall_left--;
         rsp_tready <= 1'b0;
      end else begin
         stall_left = pick_gap(stall_pct);
         rsp_tready <= (stall_left == 0);
         if (stall_left > 0)
            stall_left--;
      end
   end

   // Watchdog: too long without any accepted item ends the run.
   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready) ||
          (csr_valid && csr_ready)) begin
         quiet_cycles = 0;
      end else begin
         quiet_cycles++;
         if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("%0t: no item accepted for %0d cycles", $time, quiet_cycles);
            $display("quadrature_encoder_gesture_unit regression: fail");
            $finish;
         end
      end
   end

   // First sample after reset, press and release, press report at reset settings.
   task automatic test_startup_and_press();
      send_pin(2'b11, 1'b0);
      send_ticks(2);
      set_push(1'b1);
      set_push(1'b0);
      send_ticks(14);
   endtask

   // Right and left reports, and a count that only reaches the threshold.
   task automatic test_turn_reports();
      configure(8'd2, 8'd1, 1'b0);
      move_knob(1, 3);
      send_ticks(4);
      move_knob(-1, 2);
      send_ticks(1);
      move_knob(-1, 1);
      send_ticks(4);
   endtask

   // Invalid jumps, unchanged AB, moving while settling, inversion, press with turn.
   task automatic test_special_cases();
      send_pin(QUAD_SEQ[2'((quad_pos + 2) & 3)], push_level);
      set_push(1'b1);
      set_push(1'b0);
      set_push(1'b1);
      move_knob(1, 3);
      send_ticks(1);
      move_knob(1, 1);
      send_ticks(3);
      write_csr(CSR_INVERT_DIRECTION, 8'd1);
      write_csr(CSR_UNUSED_INDEX, 8'hFF);
      move_knob(1, 3);
      set_push(1'b0);
      send_ticks(4);
      set_push(1'b1);
      write_csr(CSR_INVERT_DIRECTION, 8'd0);
   endtask

   // Lowering the settle time below the running wait count makes it wrap.
   task automatic test_settle_wrap();
      configure(8'd0, 8'd8, 1'b0);
      move_knob(1, 1);
      send_ticks(6);
      write_csr(CSR_SETTLE_TICKS, 8'd2);
      send_ticks(258);
   endtask

   // Long output hold-off while items keep coming, so the input stalls.
   task automatic test_backpressure();
      drain_pipeline();
      idle_pct = 0;
      stall_pct = 0;
      hold_request = 1'b1;
      @(posedge clock);
      repeat (6) begin
         move_knob(1, 2);
         send_ticks(2);
      end
      drain_pipeline();
      idle_pct = 30;
      stall_pct = 30;
   endtask

   // Random gestures and noise over several register settings.
   task automatic test_random_phases();
      int         phase_end;
      int         choice;
      int         n;
      logic [2:0] raw;
      logic [7:0] thr_set;
      logic [7:0] settle_set;
      logic       inv_set;
      for (int ph = 0; ph < 6; ph++) begin
         case (ph)
            0: begin
               thr_set = STEP_THRESHOLD_RST; settle_set = SETTLE_TICKS_RST; inv_set = 1'b0;
            end
            1: begin
               thr_set = 8'd0; settle_set = 8'd0; inv_set = 1'b1;
            end
            2: begin
               thr_set = 8'd255; settle_set = 8'd3; inv_set = 1'b0;
            end
            3: begin
               thr_set = 8'd1; settle_set = 8'd255; inv_set = 1'b1;
            end
            default: begin
               thr_set = 8'($urandom_range(0, 9));
               settle_set = 8'($urandom_range(0, 12));
               inv_set = 1'($urandom_range(0, 1));
            end
         endcase
         configure(thr_set, settle_set, inv_set);
         // One setting runs without any idling on either side.
         idle_pct = (ph == 2) ? 0 : $urandom_range(10, 50);
         stall_pct = (ph == 2) ? 0 : $urandom_range(10, 50);
         phase_end = sent_items + 50;
         while (sent_items < phase_end) begin
            choice = $urandom_range(0, 99);
            if (choice < 45) begin
               move_knob($urandom_range(0, 1) ? 1 : -1, $urandom_range(1, 12));
            end else if (choice < 58) begin
               set_push(1'b0);
               if ($urandom_range(0, 3) != 0)
                  set_push(1'b1);
            end else if (choice < 88) begin
               n = ($urandom_range(0, 9) < 7) ? $urandom_range(1, 6)
                                              : $urandom_range(1, settle_set + 4);
               send_ticks(n);
            end else begin
               raw = 3'($urandom_range(0, 7));
               send_pin(raw[1:0], raw[2]);
            end
         end
      end
      idle_pct = 30;
      stall_pct = 30;
   endtask

   initial begin
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      test_startup_and_press();
      test_turn_reports();
      test_special_cases();
      test_settle_wrap();
      test_backpressure();
      test_random_phases();
      drain_pipeline();
      $display("Run covered %0d items: directed cases, wait wrap, hold-off and six random",
               sent_items);
      $display("settings; %0d right, %0d left, %0d press reports.",
               right_seen, left_seen, press_seen);
      if (errors == 0) begin
         $display("quadrature_encoder_gesture_unit regression: pass");
      end else begin
         $display("%0d mismatches", errors);
         $display("quadrature_encoder_gesture_unit regression: fail");
      end
      $finish;
   end

endmodule

FILE: filelist.f
sv/qeg_pkg.sv
sv/qeg_csr.sv
sv/qeg_core.sv
sv/quadrature_encoder_gesture_unit.sv
sim/testbench.sv
